### rtl/sfe_pkg.sv
// ----------------------------------------------------------------------------
// sfe_pkg
// Types and constants shared by the SBUS frame encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sfe_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int IDX_W        = 4;
  localparam int VALUE_W      = 16;
  localparam int COUNT_W      = 11;
  localparam int PROD_W       = 2 * VALUE_W;
  localparam int FRAC_BITS    = 12;
  localparam int QUOT_W       = PROD_W - FRAC_BITS;
  localparam int PACKED_W     = MAX_CHANNELS * COUNT_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 11'h7FF;
  localparam logic [PROD_W-1:0]  ROUND_HALF = 32'd2048;

  localparam logic [VALUE_W-1:0] OFFSET_RESET = 16'd880;
  localparam logic [VALUE_W-1:0] GAIN_RESET   = 16'd6554;

  localparam int FRAME_LEN  = 25;
  localparam int DATA_BYTES = 22;
  localparam int BCNT_W     = 5;

  localparam logic [7:0] HEADER_BYTE = 8'h0F;
  localparam logic [7:0] FILL_BYTE   = 8'h00;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic [0:0] {
    REG_SCALE_OFFSET = 1'b0,
    REG_SCALE_GAIN   = 1'b1
  } cfg_reg_t;

  // One scaled channel on its way from the front end to the frame builder.
  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic [COUNT_W-1:0] count;
    logic               last;
  } chan_entry_t;

endpackage

`default_nettype wire

### rtl/sfe_front.sv
// ----------------------------------------------------------------------------
// sfe_front
// Accepts raw channel values, scales them to 11-bit counts in a two-stage
// pipeline and pushes them, tagged with slot and end of frame, into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_front import sfe_pkg::*; #(
  parameter int NUM_CHANNELS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_write_en,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [VALUE_W-1:0] cfg_data,
  input  wire logic [VALUE_W-1:0] in_channel_value,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [QCNT_W-1:0]  q_count,
  output logic                    push,
  output chan_entry_t             push_entry
);

  logic [VALUE_W-1:0] offset_r, gain_r;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic               s1_v_r, s2_v_r;
  logic [VALUE_W-1:0] s1_diff_r, s1_gain_r, diff_nxt;
  logic [IDX_W-1:0]   s1_idx_r, s2_idx_r;
  logic               s1_last_r, s2_last_r;
  logic [PROD_W-1:0]  prod_r, prod_nxt, rounded;
  logic [QUOT_W-1:0]  quot;
  logic [QCNT_W:0]    occupancy;
  logic               accept, frame_end;

  // Items in flight are counted against the queue space so the pipeline
  // never has to stall once an item is taken.
  assign occupancy = {1'b0, q_count} + (QCNT_W+1)'(s1_v_r) + (QCNT_W+1)'(s2_v_r);
  assign in_ready  = occupancy < (QCNT_W+1)'(QUEUE_DEPTH);
  assign accept    = in_valid && in_ready;

  assign frame_end = cnt_r == IDX_W'(NUM_CHANNELS - 1);
  assign cnt_nxt   = frame_end ? '0 : cnt_r + IDX_W'(1);
  assign diff_nxt  = (in_channel_value >= offset_r) ? in_channel_value - offset_r : '0;
  assign prod_nxt  = PROD_W'(s1_diff_r) * PROD_W'(s1_gain_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RESET;
      gain_r   <= GAIN_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCALE_OFFSET: offset_r <= cfg_data;
        REG_SCALE_GAIN:   gain_r   <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_diff_r <= diff_nxt;
      s1_gain_r <= gain_r;
      s1_idx_r  <= cnt_r;
      s1_last_r <= frame_end;
    end
    if (s1_v_r) begin
      prod_r    <= prod_nxt;
      s2_idx_r  <= s1_idx_r;
      s2_last_r <= s1_last_r;
    end
  end

  // Round half up, drop the fraction and saturate to the 11-bit range.
  assign rounded = prod_r + ROUND_HALF;
  assign quot    = rounded[PROD_W-1:FRAC_BITS];

  assign push             = s2_v_r;
  assign push_entry.idx   = s2_idx_r;
  assign push_entry.count = (quot > QUOT_W'(COUNT_MAX)) ? COUNT_MAX : quot[COUNT_W-1:0];
  assign push_entry.last  = s2_last_r;

endmodule

`default_nettype wire

### rtl/sfe_queue.sv
// ----------------------------------------------------------------------------
// sfe_queue
// Small first-in first-out queue of scaled channels between the scaling
// front end and the frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_queue import sfe_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  chan_entry_t       push_entry,
  input  wire logic         pop,
  output logic              q_valid,
  output chan_entry_t       q_head,
  output logic [QCNT_W-1:0] q_count
);

  chan_entry_t       entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  assign q_valid = count_r != '0;
  assign q_head  = entries_r[rd_ptr_r];
  assign q_count = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < QCNT_W'(QUEUE_DEPTH)) || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("queue read while empty");

endmodule

`default_nettype wire

### rtl/sfe_back.sv
// ----------------------------------------------------------------------------
// sfe_back
// Keeps the channel store, and on the last channel of a frame packs the
// store into a shift register and sends the 25 frame bytes out in order.
// ----------------------------------------------------------------------------
`default_nettype none

module sfe_back import sfe_pkg::*; #(
  parameter int NUM_CHANNELS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  chan_entry_t q_head,
  output logic       pop,
  output logic [7:0] out_frame_byte,
  output logic       out_last_byte,
  output logic       out_valid,
  input  wire logic  out_ready
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_EMIT = 3'b100
  } emit_state_t;

  emit_state_t         state_r, state_nxt;
  logic [PACKED_W-1:0] packed_store;
  logic [PACKED_W-1:0] shift_r;
  logic [BCNT_W-1:0]   bcnt_r;
  logic                out_valid_r, out_last_r;
  logic [7:0]          out_byte_r, byte_nxt;
  logic                emit, is_data, is_final;

  // Store lanes; slots past the configured channel count read as zero.
  for (genvar ch = 0; ch < MAX_CHANNELS; ch++) begin : g_lane
    if (ch < NUM_CHANNELS) begin : g_used
      logic [COUNT_W-1:0] lane_r;
      always_ff @(posedge clk) begin
        if (pop && q_head.idx == IDX_W'(ch)) begin
          lane_r <= q_head.count;
        end
      end
      assign packed_store[ch*COUNT_W +: COUNT_W] = lane_r;
    end else begin : g_unused
      assign packed_store[ch*COUNT_W +: COUNT_W] = '0;
    end
  end

  // The closing channel of a frame waits until the previous frame has gone.
  assign pop = q_valid && ((state_r == ST_IDLE) || (state_r == ST_EMIT && !q_head.last));

  assign emit     = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign is_data  = (bcnt_r != '0) && (bcnt_r <= BCNT_W'(DATA_BYTES));
  assign is_final = bcnt_r == BCNT_W'(FRAME_LEN - 1);

  always_comb begin
    priority if (bcnt_r == '0) begin
      byte_nxt = HEADER_BYTE;
    end else if (is_data) begin
      byte_nxt = shift_r[7:0];
    end else begin
      byte_nxt = FILL_BYTE;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (pop && q_head.last) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_EMIT;
      ST_EMIT: if (emit && is_final) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_LOAD) begin
        bcnt_r <= '0;
      end else if (emit) begin
        bcnt_r <= bcnt_r + BCNT_W'(1);
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD) begin
      shift_r <= packed_store;
    end else if (emit && is_data) begin
      shift_r <= shift_r >> 8;
    end
    if (emit) begin
      out_byte_r <= byte_nxt;
      out_last_r <= is_final;
    end
  end

  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;
  assign out_valid      = out_valid_r;

  a_footer_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_byte_r == FILL_BYTE)
    else $error("footer byte is not zero");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> bcnt_r < BCNT_W'(FRAME_LEN))
    else $error("byte counter ran past the frame");

endmodule

`default_nettype wire

### rtl/sbus_frame_encoder_core.sv
// ----------------------------------------------------------------------------
// sbus_frame_encoder_core
// Builds 25-byte SBUS frames from raw channel values.
//
// Input channel: one raw 16-bit value per word, channels 0 to NUM_CHANNELS-1
// in order. Each is offset, scaled by a Q4.12 gain, rounded and saturated to
// an 11-bit count in a two-stage pipeline and queued for the frame builder.
// Output channel: one frame byte per word, header first; last_byte marks the
// footer. Bytes leave through an output register, so a stalled receiver
// only holds the current byte while channels keep filling the queue.
// Sequence: the closing channel of a frame passes the pipeline stages and
// the queue, is popped once the builder is idle, the store is loaded and the
// header is registered; then one byte per cycle while the receiver takes them.
// Throughput: up to one channel per cycle until the four-entry queue fills;
// sustained, it is set by the single byte output, one frame byte at a time.
// Configuration: offset at index 0, gain at index 1, written by the user only
// while the block is idle; the block does not enforce this. Reset restores the
// default offset and gain and starts at channel 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sbus_frame_encoder_core import sfe_pkg::*; #(
  parameter int NUM_CHANNELS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_write_en,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [VALUE_W-1:0] cfg_data,
  input  wire logic [VALUE_W-1:0] in_channel_value,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic [7:0]              out_frame_byte,
  output logic                    out_last_byte,
  output logic                    out_valid,
  input  wire logic               out_ready
);

  logic              push, pop, q_valid;
  chan_entry_t       push_entry, q_head;
  logic [QCNT_W-1:0] q_count;

  sfe_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_channel_value (in_channel_value),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .q_count          (q_count),
    .push             (push),
    .push_entry       (push_entry)
  );

  sfe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_count    (q_count)
  );

  sfe_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .pop            (pop),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready)
  );

endmodule

`default_nettype wire
